FILE: rtl/core/assert_macros.svh
// assertion helpers included by integer_domain_bitset_store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, quiet while reset is held
`define IBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define IBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBS_ASSERT(lbl, prop, msg)
`define IBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/ibs_pkg.sv
`timescale 1ns / 1ps
package ibs_pkg;

  // command codes
  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_NEXT     = 3'd2;
  localparam logic [2:0] CMD_PREV     = 3'd3;
  localparam logic [2:0] CMD_GAP      = 3'd4;
  localparam logic [2:0] CMD_CONTAINS = 3'd5;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_INIT     = 2'd1;
  localparam logic [1:0] ERR_SPAN     = 2'd2;
  localparam logic [1:0] ERR_CONTAINS = 2'd3;

  // what the bit scanner does at each position in range
  typedef enum logic [1:0] {
    SC_FIND1_FIRST,
    SC_FIND0_FIRST,
    SC_FIND1_LAST,
    SC_CLEAR
  } scan_op_t;

  // what follows a finished scan
  typedef enum logic [1:0] {
    PO_QUERY,
    PO_CLEAR,
    PO_MIN,
    PO_MAX
  } post_t;

endpackage

FILE: rtl/core/integer_domain_bitset_store.sv
`timescale 1ns / 1ps
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+--------------------------
// command   | in_cmd, in_operand_low, in_operand_high       | start high, busy low
// result    | out_result_value/none/flag, out_set_min/max,  | out_valid, one cycle
//           | out_set_size, out_error_code                  |
// init, out-of-set queries and bounds-only removals give the result strobe after the
// decode state, with busy already low. bitmap searches and removals walk the bitmap
// ram from offset 0 to the end of the range, or to a forward search's first hit, one
// bit per cycle while scanning, waiting to read each word (removals write it back).
// the first hole builds the bitmap, writing every word, before the clear pass.
// rst_n is synchronous; after it the set is {0} in bounds-only mode.
// results are never stalled; busy stays high from accept to the result strobe.
module integer_domain_bitset_store import ibs_pkg::*; #(
  parameter int DOMAIN_BITS = 1024,
  parameter int WORD_BITS   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_operand_low,
  input  logic signed [31:0] in_operand_high,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_result_none,
  output logic               out_result_flag,
  output logic signed [31:0] out_set_min,
  output logic signed [31:0] out_set_max,
  output logic [31:0]        out_set_size,
  output logic [1:0]         out_error_code
);

`include "assert_macros.svh"

  localparam int NWORDS = (DOMAIN_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int OFS_W  = $clog2(DOMAIN_BITS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int SPAN_W = $clog2(DOMAIN_BITS + 1);
  localparam int CNT_W  = OFS_W + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_FILL = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_LD   = 8'b0001_0000,
    S_BIT  = 8'b0010_0000,
    S_WB   = 8'b0100_0000,
    S_POST = 8'b1000_0000
  } state_t;

  state_t             state_r;
  logic [2:0]         cmd_r;
  logic signed [31:0] lo_r, hi_r;
  logic signed [31:0] lb_r, ub_r, base_r;
  logic [31:0]        cnt_r;
  logic               bm_r;
  logic [SPAN_W-1:0]  span_r;
  logic signed [31:0] clo_r, chi_r;
  scan_op_t           op_r;
  post_t              post_r;
  logic [OFS_W-1:0]   start_ofs_r, end_ofs_r, ofs_r, fofs_r;
  logic [AW-1:0]      widx_r;
  logic [BIT_W-1:0]   bit_r;
  logic [WORD_BITS-1:0] word_r;
  logic               found_r, done_r;
  logic [CNT_W-1:0]   clr_r;
  logic [31:0]        fill_ofs_r;
  logic signed [31:0] res_value_r;
  logic               res_none_r, res_flag_r, out_valid_r;
  logic [1:0]         err_r;

  // offset of a value from a bitmap base
  function automatic logic [OFS_W-1:0] rel(input logic signed [31:0] v,
                                           input logic signed [31:0] b);
    logic [32:0] d;
    d = {v[31], v} - {b[31], b};
    return d[OFS_W-1:0];
  endfunction

  // decode helpers
  logic signed [32:0] lo33, hi33, lb33, ub33, clo33, chi33;
  logic signed [31:0] clo, chi, lo_p1, lo_m1, gap_x, found_val;
  logic [32:0]        width_u, cut_low, cut_high;
  logic               contig;

  always_comb begin
    lo33     = {lo_r[31], lo_r};
    hi33     = {hi_r[31], hi_r};
    lb33     = {lb_r[31], lb_r};
    ub33     = {ub_r[31], ub_r};
    clo      = (lo_r < lb_r) ? lb_r : lo_r;
    chi      = (hi_r > ub_r) ? ub_r : hi_r;
    clo33    = {clo[31], clo};
    chi33    = {chi[31], chi};
    lo_p1    = lo_r + 32'sd1;
    lo_m1    = lo_r - 32'sd1;
    gap_x    = (lo_r < lb_r) ? (lb_r + 32'sd1) : lo_p1;
    width_u  = ub33 - lb33 + 33'sd1;
    cut_low  = chi33 + 33'sd1 - lb33;
    cut_high = ub33 - clo33 + 33'sd1;
    contig   = (width_u == {1'b0, cnt_r});
    found_val = base_r + $signed({{(32-OFS_W){1'b0}}, fofs_r});
  end

  // bitmap word ram
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, fill_mask;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      fill_mask[b] = (fill_ofs_r + 32'(b)) < 32'(span_r);
    end
  end

  assign ram_we    = (state_r == S_FILL) || (state_r == S_WB);
  assign ram_wdata = (state_r == S_FILL) ? fill_mask : word_r;

  ibs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (widx_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // bit scanner view of the current position
  logic cur_bit, in_rng, at_end, word_end, hit1, hit0;

  always_comb begin
    cur_bit  = word_r[bit_r];
    in_rng   = ofs_r >= start_ofs_r;
    at_end   = ofs_r == end_ofs_r;
    word_end = bit_r == BIT_W'(WORD_BITS - 1);
    hit1     = in_rng && cur_bit;
    hit0     = in_rng && !cur_bit;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lb_r        <= '0;
      ub_r        <= '0;
      cnt_r       <= 32'd1;
      bm_r        <= 1'b0;
      base_r      <= '0;
      span_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_cmd;
            lo_r    <= in_operand_low;
            hi_r    <= in_operand_high;
            state_r <= S_DEC;
          end
        end

        S_DEC: begin
          res_value_r <= '0;
          res_none_r  <= 1'b0;
          res_flag_r  <= 1'b0;
          err_r       <= ERR_OK;
          ofs_r       <= '0;
          widx_r      <= '0;
          found_r     <= 1'b0;
          clr_r       <= '0;
          done_r      <= 1'b0;
          fill_ofs_r  <= '0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          unique case (cmd_r)
            CMD_INIT: begin
              if ((lo_r > hi_r) || (lo_r == 32'sh8000_0000) ||
                  (hi_r == 32'sh7fff_ffff)) begin
                err_r <= ERR_INIT;
              end else begin
                lb_r   <= lo_r;
                ub_r   <= hi_r;
                cnt_r  <= 32'(hi33 - lo33 + 33'sd1);
                bm_r   <= 1'b0;
                base_r <= lo_r;
                span_r <= '0;
              end
            end
            CMD_REMOVE: begin
              clo_r  <= clo;
              chi_r  <= chi;
              op_r   <= SC_CLEAR;
              post_r <= PO_CLEAR;
              if (lo_r > hi_r) begin
                res_flag_r <= 1'b1;
              end else if ((lo_r <= lb_r) && (ub_r <= hi_r)) begin
                res_flag_r <= 1'b0;
              end else if ((hi_r < lb_r) || (ub_r < lo_r)) begin
                res_flag_r <= 1'b1;
              end else if (bm_r) begin
                start_ofs_r <= rel(clo, base_r);
                end_ofs_r   <= rel(chi, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end else if (clo == lb_r) begin
                cnt_r      <= cnt_r - cut_low[31:0];
                lb_r       <= chi + 32'sd1;
                res_flag_r <= 1'b1;
              end else if (ub_r <= chi) begin
                cnt_r      <= cnt_r - cut_high[31:0];
                ub_r       <= clo - 32'sd1;
                res_flag_r <= 1'b1;
              end else if (width_u > 33'(DOMAIN_BITS)) begin
                err_r <= ERR_SPAN;
              end else begin
                // first hole: build the bitmap at the current minimum
                bm_r        <= 1'b1;
                base_r      <= lb_r;
                span_r      <= width_u[SPAN_W-1:0];
                start_ofs_r <= rel(clo, lb_r);
                end_ofs_r   <= rel(chi, lb_r);
                out_valid_r <= 1'b0;
                state_r     <= S_FILL;
              end
            end
            CMD_NEXT: begin
              op_r   <= SC_FIND1_FIRST;
              post_r <= PO_QUERY;
              if (lo_r >= ub_r) begin
                res_none_r <= 1'b1;
              end else if (lo_r < lb_r) begin
                res_value_r <= lb_r;
              end else if (!bm_r || contig) begin
                res_value_r <= lo_p1;
              end else begin
                start_ofs_r <= rel(lo_p1, base_r);
                end_ofs_r   <= rel(ub_r, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end
            end
            CMD_PREV: begin
              op_r   <= SC_FIND1_LAST;
              post_r <= PO_QUERY;
              if (lo_r <= lb_r) begin
                res_none_r <= 1'b1;
              end else if (lo_r > ub_r) begin
                res_value_r <= ub_r;
              end else if (!bm_r || contig) begin
                res_value_r <= lo_m1;
              end else begin
                start_ofs_r <= rel(lb_r, base_r);
                end_ofs_r   <= rel(lo_m1, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end
            end
            CMD_GAP: begin
              op_r   <= SC_FIND0_FIRST;
              post_r <= PO_QUERY;
              if ((lo33 >= ub33 - 33'sd1) || !bm_r || contig) begin
                res_none_r <= 1'b1;
              end else begin
                start_ofs_r <= rel(gap_x, base_r);
                end_ofs_r   <= rel(ub_r, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end
            end
            CMD_CONTAINS: begin
              op_r   <= SC_FIND0_FIRST;
              post_r <= PO_QUERY;
              if (lo_r > hi_r) begin
                err_r <= ERR_CONTAINS;
              end else if ((lo_r >= lb_r) && (hi_r <= ub_r)) begin
                res_flag_r <= 1'b1;
                if (bm_r && !contig) begin
                  start_ofs_r <= rel(lo_r, base_r);
                  end_ofs_r   <= rel(hi_r, base_r);
                  out_valid_r <= 1'b0;
                  state_r     <= S_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end

        // write the initial all-members pattern, one word a cycle
        S_FILL: begin
          fill_ofs_r <= fill_ofs_r + 32'(WORD_BITS);
          if (widx_r == AW'(NWORDS - 1)) begin
            widx_r  <= '0;
            state_r <= S_RD;
          end else begin
            widx_r <= widx_r + 1'b1;
          end
        end

        S_RD: begin
          state_r <= S_LD;
        end

        S_LD: begin
          word_r  <= ram_rdata;
          bit_r   <= '0;
          state_r <= S_BIT;
        end

        // one bit position per cycle
        S_BIT: begin
          if (((op_r == SC_FIND1_FIRST) && hit1) || ((op_r == SC_FIND0_FIRST) && hit0)) begin
            found_r <= 1'b1;
            fofs_r  <= ofs_r;
            state_r <= S_POST;
          end else begin
            if ((op_r == SC_FIND1_LAST) && hit1) begin
              found_r <= 1'b1;
              fofs_r  <= ofs_r;
            end
            if ((op_r == SC_CLEAR) && hit1) begin
              word_r[bit_r] <= 1'b0;
              clr_r         <= clr_r + 1'b1;
            end
            ofs_r <= ofs_r + 1'b1;
            bit_r <= bit_r + 1'b1;
            if (at_end) begin
              done_r  <= 1'b1;
              state_r <= (op_r == SC_CLEAR) ? S_WB : S_POST;
            end else if (word_end) begin
              if (op_r == SC_CLEAR) begin
                state_r <= S_WB;
              end else begin
                widx_r  <= widx_r + 1'b1;
                state_r <= S_RD;
              end
            end
          end
        end

        // write back a cleared word
        S_WB: begin
          if (done_r) begin
            state_r <= S_POST;
          end else begin
            widx_r  <= widx_r + 1'b1;
            state_r <= S_RD;
          end
        end

        S_POST: begin
          ofs_r       <= '0;
          widx_r      <= '0;
          found_r     <= 1'b0;
          clr_r       <= '0;
          done_r      <= 1'b0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          unique case (post_r)
            PO_QUERY: begin
              if (cmd_r == CMD_CONTAINS) begin
                res_flag_r <= !found_r;
              end else if (found_r) begin
                res_value_r <= found_val;
              end else begin
                res_none_r <= 1'b1;
              end
            end
            PO_CLEAR: begin
              cnt_r <= cnt_r - {{(32-CNT_W){1'b0}}, clr_r};
              if (clo_r == lb_r) begin
                // minimum went away: next member above the cut
                op_r        <= SC_FIND1_FIRST;
                post_r      <= PO_MIN;
                start_ofs_r <= rel(chi_r + 32'sd1, base_r);
                end_ofs_r   <= rel(ub_r, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end else if (chi_r == ub_r) begin
                // maximum went away: last member below the cut
                op_r        <= SC_FIND1_LAST;
                post_r      <= PO_MAX;
                start_ofs_r <= rel(lb_r, base_r);
                end_ofs_r   <= rel(clo_r - 32'sd1, base_r);
                out_valid_r <= 1'b0;
                state_r     <= S_RD;
              end else begin
                res_flag_r <= 1'b1;
              end
            end
            PO_MIN: begin
              lb_r       <= found_val;
              res_flag_r <= 1'b1;
            end
            PO_MAX: begin
              ub_r       <= found_val;
              res_flag_r <= 1'b1;
            end
            default: begin
            end
          endcase
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = res_value_r;
  assign out_result_none  = res_none_r;
  assign out_result_flag  = res_flag_r;
  assign out_set_min      = lb_r;
  assign out_set_max      = ub_r;
  assign out_set_size     = cnt_r;
  assign out_error_code   = err_r;

  // checks
  `IBS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `IBS_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `IBS_ASSERT(a_strobe_idle, out_valid |-> !busy, "result strobe while still busy")
  `IBS_ASSERT(a_bounds_order, out_valid |-> (lb_r <= ub_r), "set minimum above maximum")
  `IBS_ASSERT(a_size_span, (out_valid && bm_r) |-> (cnt_r <= 32'(span_r)), "size exceeds bitmap span")

endmodule

FILE: rtl/core/ibs_ram.sv
`timescale 1ns / 1ps
module ibs_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: verif/integer_domain_bitset_store_tb.sv
`timescale 1ns / 1ps
module integer_domain_bitset_store_tb import ibs_pkg::*;;

  localparam int DOMAIN = 1024;
  localparam longint S32MIN = -64'sd2147483648;
  localparam longint S32MAX = 64'sd2147483647;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic signed [31:0] value;
    logic               none;
    logic               flag;
    logic signed [31:0] smin;
    logic signed [31:0] smax;
    logic [31:0]        size;
    logic [1:0]         err;
  } set_answer_t;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 typed;
    set_answer_t        ans;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_cmd = CMD_INIT;
  logic signed [31:0] in_operand_low = '0;
  logic signed [31:0] in_operand_high = '0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic out_result_none;
  logic out_result_flag;
  logic signed [31:0] out_set_min;
  logic signed [31:0] out_set_max;
  logic [31:0] out_set_size;
  logic [1:0] out_error_code;

  // typed expectation for the row being driven
  bit typed_pending = 1'b0;
  set_answer_t typed_ans;

  set_answer_t pending_answers[$];
  cmd_row_t rows[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  // set model state
  longint set_lo, set_hi, map_base;
  int unsigned set_count, map_span;
  bit map_on;
  bit [DOMAIN-1:0] map_bits;

  integer_domain_bitset_store dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_operand_low(in_operand_low), .in_operand_high(in_operand_high),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_result_none(out_result_none), .out_result_flag(out_result_flag),
    .out_set_min(out_set_min), .out_set_max(out_set_max), .out_set_size(out_set_size),
    .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit is_member(longint v);
    longint d;
    if (v < set_lo || v > set_hi) return 1'b0;
    if (!map_on) return 1'b1;
    d = v - map_base;
    if (d < 0 || d >= longint'(map_span) || d >= DOMAIN) return 1'b0;
    return map_bits[d];
  endfunction

  function automatic bit is_solid();
    return (set_hi - set_lo + 1) == longint'(set_count);
  endfunction

  function automatic bit find_next(longint v, output longint r);
    longint x;
    r = 0;
    if (v >= set_hi) return 1'b0;
    if (v < set_lo) begin r = set_lo; return 1'b1; end
    if (!map_on || is_solid()) begin r = v + 1; return 1'b1; end
    for (x = v + 1; x <= set_hi; x++)
      if (is_member(x)) begin r = x; return 1'b1; end
    return 1'b0;
  endfunction

  function automatic bit find_prev(longint v, output longint r);
    longint x;
    r = 0;
    if (v <= set_lo) return 1'b0;
    if (v > set_hi) begin r = set_hi; return 1'b1; end
    if (!map_on || is_solid()) begin r = v - 1; return 1'b1; end
    for (x = v - 1; x >= set_lo; x--)
      if (is_member(x)) begin r = x; return 1'b1; end
    return 1'b0;
  endfunction

  function automatic bit find_hole(longint v, output longint r);
    longint x;
    r = 0;
    if (v >= set_hi - 1 || !map_on || is_solid()) return 1'b0;
    x = (v < set_lo) ? set_lo + 1 : v + 1;
    for (; x <= set_hi; x++)
      if (!is_member(x)) begin r = x; return 1'b1; end
    return 1'b0;
  endfunction

  // range removal, building the bitmap on the first interior hole
  function automatic bit remove_span(longint lo, longint hi, output logic [1:0] err);
    longint x;
    bit drop_min, drop_max;
    err = ERR_OK;
    drop_min = 1'b0;
    drop_max = 1'b0;
    if (lo > hi) return 1'b1;
    if (lo <= set_lo && set_hi <= hi) return 1'b0;
    if (hi < set_lo || set_hi < lo) return 1'b1;
    if (lo < set_lo) lo = set_lo;
    if (hi > set_hi) hi = set_hi;
    if (!map_on) begin
      if (lo <= set_lo) begin
        set_count -= 32'(hi + 1 - set_lo);
        set_lo = hi + 1;
        return 1'b1;
      end
      if (set_hi <= hi) begin
        set_count -= 32'(set_hi - lo + 1);
        set_hi = lo - 1;
        return 1'b1;
      end
      if (set_hi - set_lo + 1 > DOMAIN) begin
        err = ERR_SPAN;
        return 1'b0;
      end
      map_on = 1'b1;
      map_base = set_lo;
      map_span = 32'(set_hi - set_lo + 1);
      map_bits = '0;
      for (x = 0; x < map_span; x++) map_bits[x] = 1'b1;
    end
    for (x = lo; x <= hi; x++) begin
      if (is_member(x)) begin
        map_bits[x - map_base] = 1'b0;
        set_count--;
        if (x == set_lo) drop_min = 1'b1;
        if (x == set_hi) drop_max = 1'b1;
      end
    end
    if (drop_min) begin
      for (x = set_lo; x <= set_hi && !is_member(x); x++) begin end
      set_lo = x;
    end
    if (drop_max) begin
      for (x = set_hi; x >= set_lo && !is_member(x); x--) begin end
      set_hi = x;
    end
    return 1'b1;
  endfunction

  function automatic set_answer_t apply_cmd(logic [2:0] cmd, longint lo, longint hi);
    set_answer_t a;
    longint r;
    longint x;
    a = '{default: '0};
    case (cmd)
      CMD_INIT: begin
        if (lo > hi || lo == S32MIN || hi == S32MAX) a.err = ERR_INIT;
        else begin
          set_lo = lo;
          set_hi = hi;
          set_count = 32'(hi - lo + 1);
          map_on = 1'b0;
          map_base = lo;
          map_span = 0;
        end
      end
      CMD_REMOVE: a.flag = remove_span(lo, hi, a.err);
      CMD_NEXT: if (find_next(lo, r)) a.value = r[31:0]; else a.none = 1'b1;
      CMD_PREV: if (find_prev(lo, r)) a.value = r[31:0]; else a.none = 1'b1;
      CMD_GAP: if (find_hole(lo, r)) a.value = r[31:0]; else a.none = 1'b1;
      CMD_CONTAINS: begin
        if (lo > hi) a.err = ERR_CONTAINS;
        else if (lo >= set_lo && hi <= set_hi) begin
          a.flag = 1'b1;
          if (map_on && !is_solid())
            for (x = lo; x <= hi; x++)
              if (!is_member(x)) begin a.flag = 1'b0; break; end
        end
      end
      default: ;
    endcase
    a.smin = set_lo[31:0];
    a.smax = set_hi[31:0];
    a.size = set_count;
    return a;
  endfunction

  // accept transactions, predict and check results
  always @(posedge clk) begin
    set_answer_t want;
    if (!rst_n) begin
      set_lo = 0;
      set_hi = 0;
      set_count = 1;
      map_on = 1'b0;
      map_base = 0;
      map_span = 0;
      map_bits = '0;
      pending_answers.delete();
    end else begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          report("result without pending transaction", 1, 0);
        end else begin
          want = pending_answers.pop_front();
          if (out_result_value !== want.value) report("value", out_result_value, want.value);
          if (out_result_none !== want.none) report("none", out_result_none, want.none);
          if (out_result_flag !== want.flag) report("flag", out_result_flag, want.flag);
          if (out_set_min !== want.smin) report("set_min", out_set_min, want.smin);
          if (out_set_max !== want.smax) report("set_max", out_set_max, want.smax);
          if (out_set_size !== want.size) report("set_size", out_set_size, want.size);
          if (out_error_code !== want.err) report("error", out_error_code, want.err);
        end
      end
      if (start && !busy) begin
        want = apply_cmd(in_cmd, longint'(in_operand_low), longint'(in_operand_high));
        pending_answers.push_back(typed_pending ? typed_ans : want);
      end
    end
  end

  task automatic send(logic [2:0] cmd, longint lo, longint hi, bit typed, set_answer_t ans);
    int gap;
    in_cmd <= cmd;
    in_operand_low <= lo[31:0];
    in_operand_high <= hi[31:0];
    typed_pending <= typed;
    typed_ans <= ans;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() > 0) @(posedge clk);
  endtask

  task automatic add_row(logic [2:0] cmd, longint lo, longint hi, bit typed,
                         longint v, bit none, bit flag, longint mn, longint mx,
                         longint sz, logic [1:0] err);
    cmd_row_t r;
    r.cmd = cmd;
    r.lo = lo[31:0];
    r.hi = hi[31:0];
    r.typed = typed;
    r.ans = '{v[31:0], none, flag, mn[31:0], mx[31:0], sz[31:0], err};
    rows.push_back(r);
  endtask

  function automatic longint clamp32(longint v);
    if (v < S32MIN) return S32MIN;
    if (v > S32MAX) return S32MAX;
    return v;
  endfunction

  // operand near the current set, sometimes anywhere
  function automatic longint near_set();
    if ($urandom_range(9) == 0) return longint'($signed($urandom));
    return clamp32(set_lo - 3 + longint'($urandom_range(0, 32'(set_hi - set_lo + 6))));
  endfunction

  task automatic random_item();
    int pick;
    longint lo, hi, ctr;
    set_answer_t none_ans;
    none_ans = '{default: '0};
    pick = $urandom_range(99);
    if (pick < 8) begin
      ctr = ($urandom_range(7) == 0) ? longint'($signed($urandom))
                                    : longint'($urandom_range(0, 8000)) - 4000;
      lo = ctr;
      hi = clamp32(ctr + (($urandom_range(9) == 0) ? $urandom_range(150, 1100)
                                                   : $urandom_range(0, 150)));
      if ($urandom_range(19) == 0) hi = lo - 1;
      send(CMD_INIT, lo, hi, 1'b0, none_ans);
    end else if (pick < 40) begin
      lo = near_set();
      hi = ($urandom_range(9) == 0) ? near_set() : clamp32(lo + $urandom_range(0, 6));
      send(CMD_REMOVE, lo, hi, 1'b0, none_ans);
    end else if (pick < 98) begin
      lo = near_set();
      hi = ($urandom_range(9) == 0) ? near_set() : clamp32(lo + $urandom_range(0, 10));
      send(3'($urandom_range(CMD_NEXT, CMD_CONTAINS)), lo, hi, 1'b0, none_ans);
    end else begin
      send(3'($urandom_range(6, 7)), $signed($urandom), $signed($urandom), 1'b0, none_ans);
    end
  endtask

  initial begin
    int i;
    int phase;
    int pcts[4];
    pcts = '{0, 86, 13, 0};

    // directed table: extremes, every command, the special cases
    add_row(CMD_NEXT, -1, 0, 1, 0, 0, 0, 0, 0, 1, ERR_OK);
    add_row(CMD_PREV, 0, 0, 1, 0, 1, 0, 0, 0, 1, ERR_OK);
    add_row(CMD_INIT, 5, 3, 1, 0, 0, 0, 0, 0, 1, ERR_INIT);
    add_row(CMD_INIT, S32MIN, 0, 1, 0, 0, 0, 0, 0, 1, ERR_INIT);
    add_row(CMD_INIT, 0, S32MAX, 1, 0, 0, 0, 0, 0, 1, ERR_INIT);
    add_row(CMD_INIT, S32MIN + 1, S32MAX - 1, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1,
            64'd4294967294, ERR_OK);
    add_row(CMD_NEXT, S32MAX, 0, 1, 0, 1, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_OK);
    add_row(CMD_PREV, S32MIN, 0, 1, 0, 1, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_OK);
    add_row(CMD_CONTAINS, S32MIN + 1, S32MAX - 1, 1, 0, 0, 1, S32MIN + 1, S32MAX - 1,
            64'd4294967294, ERR_OK);
    add_row(CMD_CONTAINS, 3, 2, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294,
            ERR_CONTAINS);
    add_row(CMD_REMOVE, 0, 0, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_SPAN);
    add_row(CMD_REMOVE, S32MIN, S32MAX, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1,
            64'd4294967294, ERR_OK);
    add_row(CMD_GAP, 0, 0, 1, 0, 1, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_OK);
    add_row(3'd6, -1, -1, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_OK);
    add_row(3'd7, 0, 0, 1, 0, 0, 0, S32MIN + 1, S32MAX - 1, 64'd4294967294, ERR_OK);
    add_row(CMD_INIT, -100, 100, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, 5, 1, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, 200, 300, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, -100, -90, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_GAP, -200, 0, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_NEXT, -1, 0, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_PREV, 1, 0, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_CONTAINS, -5, 5, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_INIT, 1000, 2023, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, 1500, 1500, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_INIT, 0, 1024, 0, 0, 0, 0, 0, 0, 0, ERR_OK);
    add_row(CMD_REMOVE, 5, 5, 0, 0, 0, 0, 0, 0, 0, ERR_OK);

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].cmd, rows[i].lo, rows[i].hi, rows[i].typed, rows[i].ans);
    typed_pending <= 1'b0;

    // random phases; the sender gap chance changes from phase to phase
    for (phase = 0; phase < 4; phase++) begin
      drain();
      idle_pct = pcts[phase];
      for (i = 0; i < 235; i++) random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ibs_pkg.sv
rtl/core/ibs_ram.sv
rtl/core/integer_domain_bitset_store.sv
verif/integer_domain_bitset_store_tb.sv
